>>> rtl/core/desa_pkg.sv
package desa_pkg;

  // Item command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_RX      = 2'd1;
  localparam logic [1:0] CMD_TX_DONE = 2'd2;

  // Serial protocol bytes
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] OP_WR_VOLT  = 8'h00;
  localparam logic [7:0] OP_WR_AMP   = 8'h01;
  localparam logic [7:0] OP_RD_VOLT  = 8'h02;
  localparam logic [7:0] OP_RD_AMP   = 8'h03;
  localparam logic [7:0] REPLY_CODE  = 8'h00;

  // Step size selections
  localparam logic [1:0] STEP_FINE   = 2'd0;
  localparam logic [1:0] STEP_MID    = 2'd1;
  localparam logic [1:0] STEP_COARSE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCAN_PERIOD = 2'd0;
  localparam logic [1:0] CFG_FINE_STEP   = 2'd1;
  localparam logic [1:0] CFG_MID_STEP    = 2'd2;
  localparam logic [1:0] CFG_COARSE_STEP = 2'd3;

  localparam int STEP_W = 12;
  localparam int SCAN_W = 8;
  localparam int CFG_W  = 12;
  localparam int WORD_W = 16;

  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 8'd2;
  localparam logic [STEP_W-1:0] FINE_STEP_RST   = 12'd1;
  localparam logic [STEP_W-1:0] MID_STEP_RST    = 12'd10;
  localparam logic [STEP_W-1:0] COARSE_STEP_RST = 12'd100;

  // Setpoint load request from the serial parser
  typedef struct packed {
    logic              volt_wr;
    logic              amp_wr;
    logic [WORD_W-1:0] word;
  } desa_load_t;

  // Transmit byte for the current request
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } desa_tx_t;

endpackage

>>> rtl/core/desa_enc.sv
module desa_enc
  import desa_pkg::*;
#(
  parameter int   VALUE_BITS = 12,
  parameter logic RESET_FULL = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_en,
  input  logic                  scan_hit,
  input  logic                  enc_a,
  input  logic                  enc_b,
  input  logic                  button_n,
  input  logic [STEP_W-1:0]     fine_step,
  input  logic [STEP_W-1:0]     mid_step,
  input  logic [STEP_W-1:0]     coarse_step,
  input  logic                  load_en,
  input  logic [VALUE_BITS-1:0] load_value,
  output logic [VALUE_BITS-1:0] value
);

  localparam int SW = ((VALUE_BITS > STEP_W) ? VALUE_BITS : STEP_W) + 1;
  localparam logic [VALUE_BITS-1:0] FULL = {VALUE_BITS{1'b1}};

  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  seen_r, seen_nxt;
  logic                  held_r, held_nxt;
  logic [1:0]            sel_r, sel_nxt;
  logic [STEP_W-1:0]     step;
  logic [SW-1:0]         sum, diff;
  logic [VALUE_BITS-1:0] up_val, down_val;

  // Pick the step for the current selection
  always_comb begin
    case (sel_r)
      STEP_MID:    step = mid_step;
      STEP_COARSE: step = coarse_step;
      default:     step = fine_step;
    endcase
  end

  // Saturate at full scale and at zero
  assign sum      = SW'(value_r) + SW'(step);
  assign diff     = SW'(value_r) - SW'(step);
  assign up_val   = (sum > SW'(FULL)) ? FULL : sum[VALUE_BITS-1:0];
  assign down_val = (SW'(value_r) < SW'(step)) ? '0 : diff[VALUE_BITS-1:0];

  always_comb begin
    value_nxt = value_r;
    seen_nxt  = seen_r;
    held_nxt  = held_r;
    sel_nxt   = sel_r;
    if (load_en) begin
      value_nxt = load_value;
    end
    if (tick_en) begin
      // Move on a rising A edge seen at the scan instant
      if (scan_hit) begin
        if (enc_a && !seen_r) begin
          value_nxt = enc_b ? down_val : up_val;
        end
        seen_nxt = enc_a;
      end
      // Advance the step selection on a press edge
      if (!button_n && !held_r) begin
        case (sel_r)
          STEP_FINE: sel_nxt = STEP_MID;
          STEP_MID:  sel_nxt = STEP_COARSE;
          default:   sel_nxt = STEP_FINE;
        endcase
      end
      held_nxt = ~button_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= RESET_FULL ? FULL : '0;
      seen_r  <= 1'b0;
      held_r  <= 1'b0;
      sel_r   <= STEP_FINE;
    end else begin
      value_r <= value_nxt;
      seen_r  <= seen_nxt;
      held_r  <= held_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign value = value_r;

endmodule

>>> rtl/core/desa_serial.sv
module desa_serial
  import desa_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_en,
  input  logic [1:0]            command,
  input  logic [7:0]            rx_byte,
  input  logic [VALUE_BITS-1:0] volt_value,
  input  logic [VALUE_BITS-1:0] amp_value,
  output desa_load_t            load,
  output desa_tx_t              tx
);

  typedef enum logic [1:0] {
    RX_SYNC,
    RX_CMD,
    RX_LOW,
    RX_HIGH
  } rx_state_t;

  typedef enum logic [2:0] {
    TX_IDLE,
    TX_SYNC,
    TX_CODE,
    TX_LOW,
    TX_HIGH
  } tx_state_t;

  rx_state_t             rx_state_r, rx_state_nxt;
  tx_state_t             tx_state_r, tx_state_nxt;
  logic                  target_r, target_nxt;
  logic [7:0]            prev_r, prev_nxt;
  logic [VALUE_BITS-1:0] tx_value_r, tx_value_nxt;
  logic [WORD_W-1:0]     tx_word;

  assign tx_word = WORD_W'(tx_value_r);

  always_comb begin
    rx_state_nxt = rx_state_r;
    tx_state_nxt = tx_state_r;
    target_nxt   = target_r;
    prev_nxt     = prev_r;
    tx_value_nxt = tx_value_r;
    load         = '0;
    tx           = '0;
    load.word    = {rx_byte, prev_r};
    if (req_en && command == CMD_RX) begin
      // Parse one received byte
      case (rx_state_r)
        RX_CMD: begin
          if (rx_byte == OP_WR_VOLT || rx_byte == OP_WR_AMP) begin
            target_nxt   = rx_byte[0];
            rx_state_nxt = RX_LOW;
          end else if (rx_byte == OP_RD_VOLT || rx_byte == OP_RD_AMP) begin
            rx_state_nxt = RX_SYNC;
            tx_state_nxt = TX_SYNC;
            tx_value_nxt = (rx_byte == OP_RD_VOLT) ? volt_value : amp_value;
            tx.valid     = 1'b1;
            tx.data      = SYNC_BYTE;
          end
        end
        RX_LOW: begin
          rx_state_nxt = RX_HIGH;
        end
        RX_HIGH: begin
          load.volt_wr = ~target_r;
          load.amp_wr  = target_r;
          rx_state_nxt = RX_SYNC;
        end
        default: begin
          if (rx_byte == SYNC_BYTE && prev_r == SYNC_BYTE) begin
            rx_state_nxt = RX_CMD;
          end
        end
      endcase
      prev_nxt = rx_byte;
    end else if (req_en && command == CMD_TX_DONE) begin
      // Advance the reply by one byte
      case (tx_state_r)
        TX_SYNC: begin
          tx.valid     = 1'b1;
          tx.data      = SYNC_BYTE;
          tx_state_nxt = TX_CODE;
        end
        TX_CODE: begin
          tx.valid     = 1'b1;
          tx.data      = REPLY_CODE;
          tx_state_nxt = TX_LOW;
        end
        TX_LOW: begin
          tx.valid     = 1'b1;
          tx.data      = tx_word[7:0];
          tx_state_nxt = TX_HIGH;
        end
        TX_HIGH: begin
          tx.valid     = 1'b1;
          tx.data      = tx_word[15:8];
          tx_state_nxt = TX_IDLE;
        end
        default: begin
          tx_state_nxt = TX_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_state_r <= RX_SYNC;
      tx_state_r <= TX_IDLE;
      target_r   <= 1'b0;
      prev_r     <= '0;
      tx_value_r <= '0;
    end else begin
      rx_state_r <= rx_state_nxt;
      tx_state_r <= tx_state_nxt;
      target_r   <= target_nxt;
      prev_r     <= prev_nxt;
      tx_value_r <= tx_value_nxt;
    end
  end

endmodule

>>> rtl/core/dual_encoder_setpoint_with_serial_access.sv
// Dual encoder setpoint block with serial access.
// Input channel: one request per valid/stall handshake, carrying a command
// (timer tick, serial byte received, serial transmit done), the encoder A/B
// pin levels and active-low buttons of both channels, and the received byte.
// Output channel: one result per request: both setpoints after the request,
// and a transmit byte with its valid flag (byte is zero when not valid).
// The result register loads at the accept edge and the setpoint outputs come
// straight from the setpoint registers.
// Throughput is one request per cycle while the receiver does not stall; all per-request work is one
// short add/compare per encoder and a few byte compares in the serial parser.
// When the receiver stalls, the held result keeps its payload and the input
// stall rises, so no request is taken until the result leaves; a new request
// is accepted in the same cycle the waiting result is taken.
// Configuration writes (scan period, fine, mid and coarse steps) go through
// cfg_wr_en/cfg_index/cfg_wr_data and should only happen while idle.
// Reset (synchronous, active low) restores the default registers, clears the
// voltage setpoint, sets the current setpoint to full scale and idles the
// serial parser and reply sequencer.
module dual_encoder_setpoint_with_serial_access
  import desa_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic                  in_volt_enc_a,
  input  logic                  in_volt_enc_b,
  input  logic                  in_volt_button_n,
  input  logic                  in_amp_enc_a,
  input  logic                  in_amp_enc_b,
  input  logic                  in_amp_button_n,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_volt_setpoint,
  output logic [VALUE_BITS-1:0] out_amp_setpoint,
  output logic                  out_tx_valid,
  output logic [7:0]            out_tx_byte,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wr_data
);

  logic [SCAN_W-1:0] scan_period_r;
  logic [STEP_W-1:0] fine_step_r, mid_step_r, coarse_step_r;
  logic [SCAN_W-1:0] scan_count_r, scan_count_nxt, scan_inc;
  logic              out_valid_r, out_valid_nxt;
  desa_tx_t          tx_r;
  desa_tx_t          tx_next;
  desa_load_t        load;
  logic              accept, tick_en, scan_hit;
  logic [VALUE_BITS-1:0] volt_value, amp_value, load_value;

  // Hold the request while a result waits
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign tick_en  = accept & (in_command == CMD_TICK);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r <= SCAN_PERIOD_RST;
      fine_step_r   <= FINE_STEP_RST;
      mid_step_r    <= MID_STEP_RST;
      coarse_step_r <= COARSE_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCAN_PERIOD: scan_period_r <= cfg_wr_data[SCAN_W-1:0];
        CFG_FINE_STEP:   fine_step_r   <= cfg_wr_data[STEP_W-1:0];
        CFG_MID_STEP:    mid_step_r    <= cfg_wr_data[STEP_W-1:0];
        CFG_COARSE_STEP: coarse_step_r <= cfg_wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan divider: wraps at the period
  assign scan_inc = scan_count_r + SCAN_W'(1);
  assign scan_hit = (scan_inc == scan_period_r);

  always_comb begin
    scan_count_nxt = scan_count_r;
    if (tick_en) begin
      scan_count_nxt = scan_hit ? '0 : scan_inc;
    end
  end

  assign load_value = load.word[VALUE_BITS-1:0];

  desa_enc #(
    .VALUE_BITS (VALUE_BITS),
    .RESET_FULL (1'b0)
  ) u_volt (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .scan_hit    (scan_hit),
    .enc_a       (in_volt_enc_a),
    .enc_b       (in_volt_enc_b),
    .button_n    (in_volt_button_n),
    .fine_step   (fine_step_r),
    .mid_step    (mid_step_r),
    .coarse_step (coarse_step_r),
    .load_en     (load.volt_wr),
    .load_value  (load_value),
    .value       (volt_value)
  );

  desa_enc #(
    .VALUE_BITS (VALUE_BITS),
    .RESET_FULL (1'b1)
  ) u_amp (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .scan_hit    (scan_hit),
    .enc_a       (in_amp_enc_a),
    .enc_b       (in_amp_enc_b),
    .button_n    (in_amp_button_n),
    .fine_step   (fine_step_r),
    .mid_step    (mid_step_r),
    .coarse_step (coarse_step_r),
    .load_en     (load.amp_wr),
    .load_value  (load_value),
    .value       (amp_value)
  );

  desa_serial #(
    .VALUE_BITS (VALUE_BITS)
  ) u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_en     (accept),
    .command    (in_command),
    .rx_byte    (in_rx_byte),
    .volt_value (volt_value),
    .amp_value  (amp_value),
    .load       (load),
    .tx         (tx_next)
  );

  // Result register: load on accept, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      scan_count_r <= scan_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_r <= tx_next;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_volt_setpoint = volt_value;
  assign out_amp_setpoint  = amp_value;
  assign out_tx_valid      = tx_r.valid;
  assign out_tx_byte       = tx_r.data;

endmodule
